>>> src/bmph_pkg.sv
`default_nettype none
package bmph_pkg;
	localparam int MAX_BONES_DEF = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_PIVOT   = 2'd1,
		ACT_POSE    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) return 32'sh7fffffff;
		if (v < -68'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

>>> src/bone_matrix_pivot_hierarchy_core.sv
`default_nettype none
// Bone matrix palette: restart (action 0) clears the frame, load (1) appends
// one pivot, pose (2) computes the next bone's 3x4 world matrix and returns it
// as four column transactions, column 3 flagged last. One 32x32 multiplier
// under a step sequencer does all products: 27 steps for the quaternion, the
// local linear part and the pivot terms, then 36 more for the parent product.
// With a posed parent a bone passes through pivot reads, the first 27 steps,
// parent matrix reads, the parent product steps, world writes and column
// delivery; a root bone skips the parent reads and product. Output stalls
// hold the column phase. Restart, unused actions, and loads and poses past
// the bone limit return straight to idle. The block is not ready while a
// pivot is being written, a bone is in work or its columns are being delivered.
module bone_matrix_pivot_hierarchy_core #(
	parameter int MAX_BONES = bmph_pkg::MAX_BONES_DEF,
	parameter int FRAC_BITS = bmph_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic signed [8:0]  parent_bone,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] quat_w,
	input  wire logic signed [31:0] quat_x,
	input  wire logic signed [31:0] quat_y,
	input  wire logic signed [31:0] quat_z,
	input  wire logic signed [31:0] scale_x,
	input  wire logic signed [31:0] scale_y,
	input  wire logic signed [31:0] scale_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       bone_number,
	output logic [1:0]       column,
	output logic signed [31:0] row0,
	output logic signed [31:0] row1,
	output logic signed [31:0] row2,
	output logic signed [31:0] row3,
	output logic             last_column
);
	import bmph_pkg::*;

	localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int CW = $clog2(MAX_BONES + 1);
	localparam int PD = MAX_BONES * 3;
	localparam int WD = MAX_BONES * 12;
	localparam int PAW = $clog2(PD);
	localparam int WAW = $clog2(WD);
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [67:0] ONE68 = 68'sd1 <<< FRAC_BITS;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PIV   = 7'b0000010,
		S_PRD   = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_WRD   = 7'b0010000,
		S_WST   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] pcnt_q, bcnt_q;
	logic [MAX_BONES-1:0] posed_q;
	logic signed [31:0] pivot_mem [PD];
	logic signed [31:0] world_mem [WD];
	logic signed [31:0] prd_q, wrd_q;

	logic signed [31:0] q_q [4];
	logic signed [31:0] s_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] pv_q [3];
	logic signed [31:0] pr_q [9];   // quaternion products
	logic signed [31:0] rot_q [9];
	logic signed [31:0] lin_q [9];
	logic signed [31:0] t_q [3];
	logic signed [31:0] pw_q [12];  // parent world matrix
	logic signed [31:0] w_q [12];
	logic signed [67:0] acc_q;
	logic has_par_q;
	logic [BW-1:0] par_q;
	logic [6:0] step_q;
	logic [3:0] idx_q;
	logic [1:0] col_q;

	// quotient by three for values below nine
	function automatic logic [1:0] third(input logic [6:0] v);
		if (v >= 7'd6) return 2'd2;
		if (v >= 7'd3) return 2'd1;
		return 2'd0;
	endfunction

	// shared multiplier
	logic signed [31:0] ma, mb, mres;
	logic signed [63:0] mp;
	assign mp = ma * mb + HALF;
	assign mres = sat32(68'(mp >>> FRAC_BITS));

	// step plan: 0..8 quat products; 9..17 L=R*s; 18..26 L*pv acc per row;
	// 27..53 W_lin (r,c,k); 54..62 P*t per row; 63 copies local as world
	logic [1:0] sr, sc, sk;
	logic [6:0] rel, rem;
	always_comb begin
		sr = '0; sc = '0; sk = '0; rel = '0; rem = '0;
		ma = '0; mb = '0;
		if (step_q < 7'd9) begin
			case (step_q[3:0])
				4'd0: begin ma = q_q[1]; mb = q_q[1]; end
				4'd1: begin ma = q_q[2]; mb = q_q[2]; end
				4'd2: begin ma = q_q[3]; mb = q_q[3]; end
				4'd3: begin ma = q_q[1]; mb = q_q[2]; end
				4'd4: begin ma = q_q[1]; mb = q_q[3]; end
				4'd5: begin ma = q_q[2]; mb = q_q[3]; end
				4'd6: begin ma = q_q[0]; mb = q_q[1]; end
				4'd7: begin ma = q_q[0]; mb = q_q[2]; end
				default: begin ma = q_q[0]; mb = q_q[3]; end
			endcase
		end else if (step_q < 7'd18) begin
			rel = step_q - 7'd9;
			sr = third(rel); sc = 2'(rel - 7'd3 * 7'(sr));
			ma = rot_q[4'(rel)]; mb = s_q[sc];
		end else if (step_q < 7'd27) begin
			rel = step_q - 7'd18;
			sr = third(rel); sc = 2'(rel - 7'd3 * 7'(sr));
			ma = lin_q[4'(rel)]; mb = pv_q[sc];
		end else if (step_q < 7'd54) begin
			rel = step_q - 7'd27;
			sr = (rel >= 7'd18) ? 2'd2 : (rel >= 7'd9) ? 2'd1 : 2'd0;
			rem = rel - 7'd9 * 7'(sr);
			sc = third(rem); sk = 2'(rem - 7'd3 * 7'(sc));
			ma = pw_q[4'({2'b0, sr} * 4 + {2'b0, sk})];
			mb = lin_q[4'({2'b0, sk} * 3 + {2'b0, sc})];
		end else if (step_q < 7'd63) begin
			rel = step_q - 7'd54;
			sr = third(rel); sk = 2'(rel - 7'd3 * 7'(sr));
			ma = pw_q[4'({2'b0, sr} * 4 + {2'b0, sk})];
			mb = t_q[sk];
		end
	end

	logic signed [67:0] accn;
	assign accn = acc_q + 68'(mres);

	logic [PAW-1:0] paddr;
	logic [WAW-1:0] waddr;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_PIV)
			pivot_mem[PAW'(pcnt_q) * PAW'(3) + PAW'(idx_q)] <= pv_q[idx_q[1:0]];
		prd_q <= pivot_mem[paddr];
		if (state_q == S_WST) world_mem[waddr] <= w_q[idx_q];
		wrd_q <= world_mem[waddr];
	end
	always_comb begin
		paddr = PAW'(bcnt_q) * PAW'(3) + PAW'(idx_q[1:0]);
		waddr = (state_q == S_WST) ? WAW'(bcnt_q) * WAW'(12) + WAW'(idx_q)
		                           : WAW'(par_q) * WAW'(12) + WAW'(idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pcnt_q <= '0; bcnt_q <= '0; posed_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0; step_q <= '0; col_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					pos_q[0] <= vec_x; pos_q[1] <= vec_y; pos_q[2] <= vec_z;
					pv_q[0] <= vec_x; pv_q[1] <= vec_y; pv_q[2] <= vec_z;
					q_q[0] <= quat_w; q_q[1] <= quat_x; q_q[2] <= quat_y; q_q[3] <= quat_z;
					s_q[0] <= scale_x; s_q[1] <= scale_y; s_q[2] <= scale_z;
					par_q <= BW'(parent_bone);
					has_par_q <= !parent_bone[8] && (32'(parent_bone) < MAX_BONES)
						&& posed_q[BW'(parent_bone)];
					idx_q <= '0; step_q <= '0; acc_q <= '0;
					case (action_t'(action))
						ACT_RESTART: begin posed_q <= '0; pcnt_q <= '0; bcnt_q <= '0; end
						ACT_PIVOT: if (32'(pcnt_q) < MAX_BONES) state_q <= S_PIV;
						ACT_POSE: if (32'(bcnt_q) < MAX_BONES) state_q <= S_PRD;
						default: ;
					endcase
				end
				S_PIV: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd2) begin pcnt_q <= pcnt_q + 1'b1; state_q <= S_IDLE; end
				end
				S_PRD: begin
					// registered read: data for idx-1 lands now
					if (idx_q != 4'd0) pv_q[2'(idx_q - 4'd1)] <=
						(bcnt_q < pcnt_q) ? prd_q : 32'sd0;
					if (idx_q == 4'd3) begin idx_q <= '0; state_q <= S_MUL; end
					else idx_q <= idx_q + 4'd1;
				end
				S_MUL: begin
					if (step_q < 7'd9) begin
						pr_q[4'(step_q)] <= mres;
						if (step_q == 7'd8) begin
							rot_q[0] <= sat32(ONE68 - 2 * (68'(pr_q[1]) + 68'(pr_q[2])));
							rot_q[3] <= sat32(2 * (68'(pr_q[3]) + 68'(mres)));
							rot_q[6] <= sat32(2 * (68'(pr_q[4]) - 68'(pr_q[7])));
							rot_q[1] <= sat32(2 * (68'(pr_q[3]) - 68'(mres)));
							rot_q[4] <= sat32(ONE68 - 2 * (68'(pr_q[0]) + 68'(pr_q[2])));
							rot_q[7] <= sat32(2 * (68'(pr_q[5]) + 68'(pr_q[6])));
							rot_q[2] <= sat32(2 * (68'(pr_q[4]) + 68'(pr_q[7])));
							rot_q[5] <= sat32(2 * (68'(pr_q[5]) - 68'(pr_q[6])));
							rot_q[8] <= sat32(ONE68 - 2 * (68'(pr_q[0]) + 68'(pr_q[1])));
						end
					end else if (step_q < 7'd18) begin
						lin_q[4'(rel)] <= mres;
					end else if (step_q < 7'd27) begin
						if (sc == 2'd2) begin
							acc_q <= '0;
							t_q[sr] <= sat32(68'(sat32(68'(pv_q[sr]) + 68'(pos_q[sr])))
								- 68'(sat32(accn)));
						end else acc_q <= accn;
					end else if (step_q < 7'd54) begin
						if (sk == 2'd2) begin
							acc_q <= '0;
							w_q[4'({2'b0, sr} * 4 + {2'b0, sc})] <= sat32(accn);
						end else acc_q <= accn;
					end else if (step_q < 7'd63) begin
						if (sk == 2'd2) begin
							acc_q <= '0;
							w_q[4'({2'b0, sr} * 4 + 4'd3)] <=
								sat32(accn + 68'(pw_q[4'({2'b0, sr} * 4 + 4'd3)]));
						end else acc_q <= accn;
					end
					if (step_q == 7'd26) begin
						idx_q <= '0;
						if (has_par_q) state_q <= S_WRD;
						else step_q <= 7'd63;
					end else if (step_q == 7'd62) begin
						idx_q <= '0; state_q <= S_WST;
					end else step_q <= step_q + 7'd1;
					if (step_q == 7'd63) begin
						for (int r = 0; r < 3; r++) begin
							for (int c = 0; c < 3; c++) w_q[r*4+c] <= lin_q[r*3+c];
							w_q[r*4+3] <= t_q[r];
						end
						idx_q <= '0; state_q <= S_WST;
					end
				end
				S_WRD: begin
					if (idx_q != 4'd0) pw_q[idx_q - 4'd1] <= wrd_q;
					if (idx_q == 4'd12) begin step_q <= 7'd27; state_q <= S_MUL; end
					idx_q <= idx_q + 4'd1;
				end
				S_WST: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd11) begin
						posed_q[BW'(bcnt_q)] <= 1'b1;
						col_q <= '0; out_valid <= 1'b1; state_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) begin
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						out_valid <= 1'b0; bcnt_q <= bcnt_q + 1'b1; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign bone_number = 8'(bcnt_q);
	assign column = col_q;
	assign row0 = w_q[{2'b0, col_q}];
	assign row1 = w_q[4'd4 + {2'b0, col_q}];
	assign row2 = w_q[4'd8 + {2'b0, col_q}];
	assign row3 = (col_q == 2'd3) ? 32'(ONE68) : 32'sd0;
	assign last_column = (col_q == 2'd3);
endmodule
`default_nettype wire

>>> sim/bone_matrix_pivot_hierarchy_checker.sv
`timescale 1ns / 1ps
module bone_matrix_pivot_hierarchy_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [1:0]         action,
	input  wire logic signed [8:0]  parent_bone,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] quat_w,
	input  wire logic signed [31:0] quat_x,
	input  wire logic signed [31:0] quat_y,
	input  wire logic signed [31:0] quat_z,
	input  wire logic signed [31:0] scale_x,
	input  wire logic signed [31:0] scale_y,
	input  wire logic signed [31:0] scale_z,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [7:0]         bone_number,
	input  wire logic [1:0]         column,
	input  wire logic signed [31:0] row0,
	input  wire logic signed [31:0] row1,
	input  wire logic signed [31:0] row2,
	input  wire logic signed [31:0] row3,
	input  wire logic               last_column,
	output int                      fail_count,
	output int                      pending_columns,
	output int                      columns_seen
);
	import bmph_pkg::*;

	localparam int NB = MAX_BONES_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;

	typedef struct packed {
		logic [7:0]         bone;
		logic [1:0]         col;
		logic signed [31:0] r0, r1, r2, r3;
		logic               last;
	} column_t;

	column_t column_queue[$];
	logic signed [31:0] pivots[NB*3];
	logic signed [31:0] world[NB*12];
	logic posed[NB];
	int pivot_cnt, bone_cnt;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b) + (longint'(1) << (FB - 1));
		return clamp32(p >>> FB);
	endfunction

	task automatic pose_bone();
		logic signed [31:0] pv[3], pos[3], sc[3], rot[3][3], lin[3][3], tr[3], w[3][4];
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz, acc, a;
		int b, par;
		column_t e;
		b = bone_cnt;
		par = parent_bone;
		pos = '{vec_x, vec_y, vec_z};
		sc = '{scale_x, scale_y, scale_z};
		pv = '{0, 0, 0};
		if (b < pivot_cnt)
			for (int i = 0; i < 3; i++) pv[i] = pivots[b*3+i];
		xx = qmul(quat_x, quat_x); yy = qmul(quat_y, quat_y); zz = qmul(quat_z, quat_z);
		xy = qmul(quat_x, quat_y); xz = qmul(quat_x, quat_z); yz = qmul(quat_y, quat_z);
		wx = qmul(quat_w, quat_x); wy = qmul(quat_w, quat_y); wz = qmul(quat_w, quat_z);
		rot[0][0] = clamp32(ONE - 2*(yy+zz));
		rot[1][0] = clamp32(2*(xy+wz));
		rot[2][0] = clamp32(2*(xz-wy));
		rot[0][1] = clamp32(2*(xy-wz));
		rot[1][1] = clamp32(ONE - 2*(xx+zz));
		rot[2][1] = clamp32(2*(yz+wx));
		rot[0][2] = clamp32(2*(xz+wy));
		rot[1][2] = clamp32(2*(yz-wx));
		rot[2][2] = clamp32(ONE - 2*(xx+yy));
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++) begin
				lin[r][c] = qmul(rot[r][c], sc[c]);
				acc += qmul(lin[r][c], pv[c]);
			end
			tr[r] = clamp32(longint'(clamp32(longint'(pv[r]) + pos[r])) - clamp32(acc));
		end
		// Treat root, out-of-range or not-yet-posed parent as identity
		if (par >= 0 && par < NB && posed[par]) begin
			for (int r = 0; r < 3; r++) begin
				acc = world[par*12 + r*4 + 3];
				for (int c = 0; c < 3; c++) begin
					a = 0;
					for (int k = 0; k < 3; k++) a += qmul(world[par*12 + r*4 + k], lin[k][c]);
					w[r][c] = clamp32(a);
				end
				for (int k = 0; k < 3; k++) acc += qmul(world[par*12 + r*4 + k], tr[k]);
				w[r][3] = clamp32(acc);
			end
		end else begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) w[r][c] = lin[r][c];
				w[r][3] = tr[r];
			end
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++) world[b*12 + r*4 + c] = w[r][c];
		posed[b] = 1'b1;
		bone_cnt = b + 1;
		for (int c = 0; c < 4; c++) begin
			e.bone = b[7:0];
			e.col = c[1:0];
			e.r0 = w[0][c]; e.r1 = w[1][c]; e.r2 = w[2][c];
			e.r3 = (c == 3) ? 32'(ONE) : 32'sd0;
			e.last = (c == 3);
			column_queue = {column_queue, e};
		end
	endtask

	initial begin
		fail_count = 0;
		columns_seen = 0;
		pivot_cnt = 0;
		bone_cnt = 0;
		foreach (posed[i]) posed[i] = 1'b0;
	end

	assign pending_columns = column_queue.size();

	always @(posedge clk) begin
		column_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{bone_number, column, row0, row1, row2, row3, last_column};
			columns_seen++;
			if (column_queue.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected column transaction %p", $time, got);
			end else begin
				want = column_queue.pop_front();
				if (got !== want) begin
					fail_count++;
					$display("%0t: column mismatch expected %p actual %p", $time, want, got);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			case (action_t'(action))
				ACT_RESTART: begin
					foreach (posed[i]) posed[i] = 1'b0;
					pivot_cnt = 0;
					bone_cnt = 0;
				end
				ACT_PIVOT: if (pivot_cnt < NB) begin
					pivots[pivot_cnt*3] = vec_x;
					pivots[pivot_cnt*3+1] = vec_y;
					pivots[pivot_cnt*3+2] = vec_z;
					pivot_cnt++;
				end
				ACT_POSE: if (bone_cnt < NB) pose_bone();
				default: ;
			endcase
		end
	end
endmodule

>>> sim/bone_matrix_pivot_hierarchy_core_test.sv
`timescale 1ns / 1ps
module bone_matrix_pivot_hierarchy_core_test;
	import bmph_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int QUIET_TAIL = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_RESTART;
	logic signed [8:0] parent_bone = '0;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] bone_number;
	logic [1:0] column;
	logic signed [31:0] row0, row1, row2, row3;
	logic last_column;
	int fail_count, pending_columns, columns_seen;
	int idle_cycles, items_sent, frame_bones, frame_pivots;
	bit calm;

	always #5 clk = ~clk;

	bone_matrix_pivot_hierarchy_core u_dut (.*);
	bone_matrix_pivot_hierarchy_checker u_chk (.*);

	// Watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			n = $urandom_range(1, 8);
			repeat (n) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 3);
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh00010000;
			3: return -32'sh00010000;
			4: return $urandom;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
		endcase
	endfunction

	// Hold valid across back-to-back items; drop it only for idle bursts
	task automatic send(input logic [1:0] act, input int par,
			input logic signed [31:0] v[3], input logic signed [31:0] q[4],
			input logic signed [31:0] s[3]);
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 3);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		parent_bone <= 9'(par);
		vec_x <= v[0]; vec_y <= v[1]; vec_z <= v[2];
		quat_w <= q[0]; quat_x <= q[1]; quat_y <= q[2]; quat_z <= q[3];
		scale_x <= s[0]; scale_y <= s[1]; scale_z <= s[2];
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_random(input logic [1:0] act, input int par);
		logic signed [31:0] v[3], q[4], s[3];
		foreach (v[i]) v[i] = pick_value();
		foreach (q[i]) q[i] = pick_value();
		foreach (s[i]) s[i] = pick_value();
		send(act, par, v, q, s);
	endtask

	initial begin
		logic signed [31:0] z3[3], one3[3], id_q[4], q[4];
		int par;
		z3 = '{0, 0, 0};
		one3 = '{32'sh10000, 32'sh10000, 32'sh10000};
		id_q = '{32'sh10000, 0, 0, 0};
		calm = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, pivots, parent chain, extremes, special cases
		send(ACT_RESTART, 0, z3, id_q, one3);
		send(ACT_PIVOT, 0, '{32'sh20000, -32'sh10000, 32'sh8000}, id_q, one3);
		send(ACT_POSE, -1, '{32'sh10000, 0, 0}, id_q, one3);
		q = '{32'sh0b505, 0, 0, 32'sh0b505};
		send(ACT_POSE, 0, '{0, 32'sh30000, 0}, q, '{32'sh20000, 32'sh8000, -32'sh10000});
		send(ACT_POSE, 1, z3, '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000},
			'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
		send(ACT_POSE, 3, '{32'sh7fffffff, 32'sh80000000, -1}, id_q, one3);
		send(ACT_POSE, 255, z3, id_q, one3);
		send(ACT_POSE, -256, z3, id_q, one3);
		send(ACT_POSE, 2, '{-1, -1, -1}, '{-1, -1, -1, -1}, '{-1, -1, -1});
		send(ACT_NONE, 0, z3, id_q, one3);
		send(ACT_PIVOT, 0, '{32'sh80000000, 32'sh7fffffff, 0}, id_q, one3);
		send(ACT_RESTART, 0, z3, id_q, one3);
		send(ACT_POSE, 0, z3, id_q, one3);
		// Fill past the bone limit; later bones run without a pivot
		send(ACT_RESTART, 0, z3, id_q, one3);
		for (int i = 0; i < 40; i++) send_random(ACT_PIVOT, 0);
		for (int i = 0; i < MAX_BONES_DEF + 2; i++)
			send_random(ACT_POSE, (i % 5 == 0) ? -1 : i - 1 - int'($urandom_range(0, 3)));

		// Random frames: mostly well-formed hierarchies, some noise
		while (items_sent < 400) begin
			if (items_sent > 340) calm = 1;
			send_random(ACT_RESTART, 0);
			frame_bones = $urandom_range(1, 12);
			frame_pivots = $urandom_range(0, frame_bones + 1);
			for (int i = 0; i < frame_pivots; i++) send_random(ACT_PIVOT, 0);
			for (int i = 0; i < frame_bones; i++) begin
				case ($urandom_range(0, 9))
					0: par = -1;
					1: par = $urandom_range(0, 255);
					2: send_random(ACT_NONE, 0);
					3: send_random(ACT_PIVOT, 0);
					default: par = (i == 0) ? -1 : $urandom_range(0, i - 1);
				endcase
				send_random(ACT_POSE, par);
			end
		end
		in_valid <= 1'b0;

		calm = 1;
		while (pending_columns != 0) @(posedge clk);
		repeat (QUIET_TAIL) @(posedge clk);
		$display("Run covered directed limit cases and random skeleton frames, %0d column checks.",
			columns_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
src/bmph_pkg.sv
src/bone_matrix_pivot_hierarchy_core.sv
sim/bone_matrix_pivot_hierarchy_checker.sv
sim/bone_matrix_pivot_hierarchy_core_test.sv
